### src/one_wire_bus_master_unit_defines.svh
// Assertion macros for the one-wire bus master unit.
// Included by the top level; expects signals named clk and rst in scope.
`ifndef ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OBW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define OBW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/obw_pkg.sv
// Shared types, constants and helpers of the one-wire bus master.
// No dependencies; the modules, interfaces and testbench all use this package.
package obw_pkg;

  localparam int TIME_WIDTH    = 16;
  localparam int BITS_PER_BYTE = 8;
  localparam int CFG_W         = 16;
  localparam int CFG_COUNT     = 8;
  localparam int CFG_IDX_W     = $clog2(CFG_COUNT);
  localparam int BITS_W        = $clog2(BITS_PER_BYTE + 1);
  localparam int BYTE_W        = 8;

  localparam logic [32:0] TIME_MAX = (33'd1 << TIME_WIDTH) - 33'd1;

  // Command opcodes.
  typedef enum logic [1:0] {
    OP_RESET    = 2'd0,
    OP_WRITE    = 2'd1,
    OP_READ     = 2'd2,
    OP_READ_BIT = 2'd3
  } opcode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_LOW   = 3'd0,
    REG_PRES_SAMPLE = 3'd1,
    REG_RESET_TAIL  = 3'd2,
    REG_SLOT_LONG   = 3'd3,
    REG_SLOT_SHORT  = 3'd4,
    REG_BIT_GAP     = 3'd5,
    REG_READ_LOW    = 3'd6,
    REG_READ_TAIL   = 3'd7
  } cfg_reg_t;

  // Slot timing registers as seen by the sequencer.
  typedef struct packed {
    logic [CFG_W-1:0] reset_low_time;
    logic [CFG_W-1:0] presence_sample_time;
    logic [CFG_W-1:0] reset_tail_time;
    logic [CFG_W-1:0] slot_long_time;
    logic [CFG_W-1:0] slot_short_time;
    logic [CFG_W-1:0] bit_gap_time;
    logic [CFG_W-1:0] read_low_time;
    logic [CFG_W-1:0] read_tail_time;
  } cfg_t;

  // One tick as presented to the sequencer.
  typedef struct packed {
    logic              cmd_valid;
    logic [1:0]        opcode;
    logic [BYTE_W-1:0] write_byte;
    logic              leave_powered;
    logic              line_level;
  } tick_t;

  // Line and status outputs for one tick.
  typedef struct packed {
    logic              drive_low;
    logic              strong_high;
    logic              busy_res;
    logic              done_res;
    logic              presence;
    logic [BYTE_W-1:0] read_value;
  } result_t;

  // Duration of a phase: zero counts as one tick, large values saturate.
  function automatic logic [TIME_WIDTH-1:0] span(input logic [CFG_W-1:0] r);
    logic [32:0] v;
    v = 33'(r);
    if (v > TIME_MAX) v = TIME_MAX;
    if (v == 33'd0) v = 33'd1;
    return v[TIME_WIDTH-1:0];
  endfunction

endpackage

### src/obw_ifs.sv
// Valid/ready channel interfaces for ticks and results.
// Depends on obw_pkg for the field widths.
interface obw_tick_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd_valid;
  logic [1:0]                opcode;
  logic [obw_pkg::BYTE_W-1:0] write_byte;
  logic                      leave_powered;
  logic                      line_level;

  modport source (output valid, cmd_valid, opcode, write_byte, leave_powered,
                  line_level, input ready);
  modport sink   (input valid, cmd_valid, opcode, write_byte, leave_powered,
                  line_level, output ready);
endinterface

interface obw_result_if;
  logic                      valid;
  logic                      ready;
  logic                      drive_low;
  logic                      strong_high;
  logic                      busy_res;
  logic                      done_res;
  logic                      presence;
  logic [obw_pkg::BYTE_W-1:0] read_value;

  modport source (output valid, drive_low, strong_high, busy_res, done_res,
                  presence, read_value, input ready);
  modport sink   (input valid, drive_low, strong_high, busy_res, done_res,
                  presence, read_value, output ready);
endinterface

### src/obw_cfg.sv
// Bank of slot timing registers with a plain write port.
// Depends on obw_pkg for the register indexes and the cfg_t struct.
module obw_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [obw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [obw_pkg::CFG_W-1:0]      cfg_data,
  output obw_pkg::cfg_t                  cfg
);
  import obw_pkg::*;

  // Registers load their standard timings at reset and take writes by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_time       <= 16'd480;
      cfg.presence_sample_time <= 16'd65;
      cfg.reset_tail_time      <= 16'd400;
      cfg.slot_long_time       <= 16'd40;
      cfg.slot_short_time      <= 16'd1;
      cfg.bit_gap_time         <= 16'd5;
      cfg.read_low_time        <= 16'd2;
      cfg.read_tail_time       <= 16'd40;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RESET_LOW:   cfg.reset_low_time       <= cfg_data;
        REG_PRES_SAMPLE: cfg.presence_sample_time <= cfg_data;
        REG_RESET_TAIL:  cfg.reset_tail_time      <= cfg_data;
        REG_SLOT_LONG:   cfg.slot_long_time       <= cfg_data;
        REG_SLOT_SHORT:  cfg.slot_short_time      <= cfg_data;
        REG_BIT_GAP:     cfg.bit_gap_time         <= cfg_data;
        REG_READ_LOW:    cfg.read_low_time        <= cfg_data;
        REG_READ_TAIL:   cfg.read_tail_time       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### src/obw_core.sv
// Phase sequencer: times reset, write and read slots, one tick per transfer.
// Depends on obw_pkg for types, widths and the span helper.
module obw_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  obw_pkg::tick_t   tick,
  input  obw_pkg::cfg_t    cfg,
  output obw_pkg::result_t res
);
  import obw_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_W_LOW    = 4'd4,
    PH_W_HIGH   = 4'd5,
    PH_W_GAP    = 4'd6,
    PH_R_LOW    = 4'd7,
    PH_R_SAMPLE = 4'd8,
    PH_R_TAIL   = 4'd9
  } phase_t;

  phase_t                phase, phase_next;
  logic [TIME_WIDTH-1:0] time_left, time_left_next;
  logic [BITS_W-1:0]     bits_left, bits_left_next;
  logic [BYTE_W-1:0]     shift_value, shift_value_next;
  logic [1:0]            command_kind, command_kind_next;
  logic                  presence_seen, presence_seen_next;
  logic                  hold_power, hold_power_next;
  logic                  powered, powered_next;
  logic [BYTE_W-1:0]     read_result, read_result_next;
  logic                  done_next;
  logic                  gap_req, bit_end, finish_req, slot_req;

  // Next state for one tick: idle takes a command; a timed phase counts down or
  // ends, then chained recovery, bit end, next slot or completion in the same tick.
  always_comb begin
    phase_next         = phase;
    time_left_next     = time_left;
    bits_left_next     = bits_left;
    shift_value_next   = shift_value;
    command_kind_next  = command_kind;
    presence_seen_next = presence_seen;
    hold_power_next    = hold_power;
    powered_next       = powered;
    read_result_next   = read_result;
    done_next          = 1'b0;
    gap_req            = 1'b0;
    bit_end            = 1'b0;
    finish_req         = 1'b0;
    slot_req           = 1'b0;

    if (phase == PH_IDLE) begin
      if (tick.cmd_valid) begin
        powered_next      = 1'b0;
        command_kind_next = tick.opcode;
        hold_power_next   = tick.leave_powered;
        if (tick.opcode == OP_RESET) begin
          phase_next     = PH_RST_LOW;
          time_left_next = span(cfg.reset_low_time);
        end else begin
          if (tick.opcode == OP_WRITE) shift_value_next = tick.write_byte;
          bits_left_next = (tick.opcode == OP_READ_BIT) ? BITS_W'(1)
                                                        : BITS_W'(BITS_PER_BYTE);
          slot_req = 1'b1;
        end
      end
    end else if (time_left > TIME_WIDTH'(1)) begin
      time_left_next = time_left - TIME_WIDTH'(1);
    end else begin
      time_left_next = '0;
      case (phase)
        PH_RST_LOW: begin
          phase_next     = PH_RST_WAIT;
          time_left_next = span(cfg.presence_sample_time);
        end
        PH_RST_WAIT: begin
          presence_seen_next = ~tick.line_level;
          phase_next         = PH_RST_TAIL;
          time_left_next     = span(cfg.reset_tail_time);
        end
        PH_RST_TAIL: finish_req = 1'b1;
        PH_W_LOW: begin
          if (bits_left == BITS_W'(1) && hold_power) begin
            powered_next = 1'b1;
            gap_req      = 1'b1;
          end else if (shift_value[0]) begin
            phase_next     = PH_W_HIGH;
            time_left_next = span(cfg.slot_long_time);
          end else begin
            gap_req = 1'b1;
          end
        end
        PH_W_HIGH: gap_req = 1'b1;
        PH_W_GAP:  bit_end = 1'b1;
        PH_R_LOW: begin
          phase_next     = PH_R_SAMPLE;
          time_left_next = TIME_WIDTH'(1);
        end
        PH_R_SAMPLE: begin
          shift_value_next = {tick.line_level, shift_value[BYTE_W-1:1]};
          phase_next       = PH_R_TAIL;
          time_left_next   = span(cfg.read_tail_time);
        end
        PH_R_TAIL: bit_end = 1'b1;
        default: begin
          phase_next     = PH_IDLE;
          time_left_next = '0;
        end
      endcase
    end

    // Recovery after a write slot; a zero gap ends the bit at once.
    if (gap_req) begin
      if (cfg.bit_gap_time == '0) begin
        bit_end = 1'b1;
      end else begin
        phase_next     = PH_W_GAP;
        time_left_next = span(cfg.bit_gap_time);
      end
    end

    // End of a bit: shift the write byte and either finish or open a slot.
    if (bit_end) begin
      if (command_kind == OP_WRITE) shift_value_next = shift_value_next >> 1;
      if (bits_left_next != '0) bits_left_next = bits_left_next - BITS_W'(1);
      if (bits_left_next == '0) finish_req = 1'b1;
      else slot_req = 1'b1;
    end

    // Open the next write or read slot.
    if (slot_req) begin
      if (command_kind_next == OP_WRITE) begin
        phase_next     = PH_W_LOW;
        time_left_next = shift_value_next[0] ? span(cfg.slot_short_time)
                                             : span(cfg.slot_long_time);
      end else begin
        phase_next     = PH_R_LOW;
        time_left_next = span(cfg.read_low_time);
      end
    end

    // Completion: latch the read value and return to idle.
    if (finish_req) begin
      if (command_kind == OP_READ) read_result_next = shift_value_next;
      else if (command_kind == OP_READ_BIT)
        read_result_next = {{(BYTE_W-1){1'b0}}, shift_value_next[BYTE_W-1]};
      phase_next     = PH_IDLE;
      time_left_next = '0;
      done_next      = 1'b1;
    end
  end

  // Sequencer state advances once per tick transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      time_left     <= '0;
      bits_left     <= '0;
      shift_value   <= '0;
      command_kind  <= '0;
      presence_seen <= 1'b0;
      hold_power    <= 1'b0;
      powered       <= 1'b0;
      read_result   <= '0;
    end else if (step) begin
      phase         <= phase_next;
      time_left     <= time_left_next;
      bits_left     <= bits_left_next;
      shift_value   <= shift_value_next;
      command_kind  <= command_kind_next;
      presence_seen <= presence_seen_next;
      hold_power    <= hold_power_next;
      powered       <= powered_next;
      read_result   <= read_result_next;
    end
  end

  // Outputs reflect the phase entered on this tick.
  always_comb begin
    res.drive_low   = (phase_next == PH_RST_LOW) || (phase_next == PH_W_LOW) ||
                      (phase_next == PH_R_LOW);
    res.strong_high = powered_next;
    res.busy_res    = (phase_next != PH_IDLE);
    res.done_res    = done_next;
    res.presence    = presence_seen_next;
    res.read_value  = read_result_next;
  end

endmodule

### src/one_wire_bus_master_unit.sv
// One-wire bus master unit: one tick transfer in, one result transfer out.
// Each result is registered and offered in the cycle after its tick transfer;
// throughput is one tick per cycle unless a waiting result is not taken.
// Synchronous active-high reset idles the sequencer, releases the line and
// loads the standard slot timings; the result register comes up empty.
// Depends on obw_pkg, obw_ifs, obw_cfg, obw_core and the defines header.
`include "one_wire_bus_master_unit_defines.svh"

module one_wire_bus_master_unit (
  input  logic                          clk,
  input  logic                          rst,
  obw_tick_if.sink                      tick,
  obw_result_if.source                  result,
  input  logic                          cfg_we,
  input  logic [obw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [obw_pkg::CFG_W-1:0]     cfg_data
);
  import obw_pkg::*;

  cfg_t    cfg;
  tick_t   tick_data;
  result_t core_res;
  result_t res_q;
  logic    res_valid;
  logic    take;

  assign tick_data = '{cmd_valid:     tick.cmd_valid,
                       opcode:        tick.opcode,
                       write_byte:    tick.write_byte,
                       leave_powered: tick.leave_powered,
                       line_level:    tick.line_level};

  // A tick is taken whenever the result register is free or being drained.
  assign tick.ready = ~res_valid | result.ready;
  assign take       = tick.valid & tick.ready;

  obw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  obw_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .tick (tick_data),
    .cfg  (cfg),
    .res  (core_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= core_res;
    end
  end

  assign result.valid       = res_valid;
  assign result.drive_low   = res_q.drive_low;
  assign result.strong_high = res_q.strong_high;
  assign result.busy_res    = res_q.busy_res;
  assign result.done_res    = res_q.done_res;
  assign result.presence    = res_q.presence;
  assign result.read_value  = res_q.read_value;

  // Every tick transfer leaves a result waiting.
  `OBW_ASSERT_NEXT(a_tick_gives_result, take, res_valid, "tick transfer gave no result")

  // A waiting result that is not taken blocks the next tick.
  `OBW_ASSERT_NOW(a_no_overrun, res_valid && !result.ready, !tick.ready, "result overrun")

  // The strong pull-up is never on while the line is pulled low.
  `OBW_ASSERT_NOW(a_no_fight, res_valid, !(res_q.drive_low && res_q.strong_high), "line fight")

endmodule

### tb/tb_top.sv
// Self-checking testbench for the one-wire bus master unit: tick transfers in,
// result transfers out, every result compared with a cycle-free tick predictor.
// Depends on obw_pkg, the channel interfaces of obw_ifs and the unit top level.
module tb_top;
  import obw_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  // Sequencer phases as tracked by the predictor.
  typedef enum logic [3:0] {
    ST_IDLE, ST_RST_LOW, ST_RST_WAIT, ST_RST_TAIL, ST_W_LOW, ST_W_HIGH,
    ST_W_GAP, ST_R_LOW, ST_R_SAMPLE, ST_R_TAIL
  } bus_phase_t;

  logic clk = 1'b0;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  obw_tick_if   tick_ch ();
  obw_result_if res_ch ();

  one_wire_bus_master_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: timing registers and sequencer.
  logic [CFG_W-1:0]      m_cfg [CFG_COUNT];
  bus_phase_t            m_phase;
  logic [TIME_WIDTH-1:0] m_left;
  logic [BITS_W-1:0]     m_bits;
  logic [BYTE_W-1:0]     m_shift;
  opcode_t               m_kind;
  logic                  m_pres;
  logic                  m_hold;
  logic                  m_power;
  logic                  m_done;
  logic [BYTE_W-1:0]     m_rdval;

  result_t pending_res_q [$];
  int      bad_count   = 0;
  int      burst_left  = 0;
  int      idle_cycles = 0;

  // Clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // A register value as a tick count: zero still lasts one tick.
  function automatic logic [TIME_WIDTH-1:0] ticks_of(input logic [CFG_W-1:0] r);
    return (r == '0) ? TIME_WIDTH'(1) : TIME_WIDTH'(r);
  endfunction

  function automatic void end_command();
    if (m_kind == OP_READ) begin
      m_rdval = m_shift;
    end else if (m_kind == OP_READ_BIT) begin
      m_rdval = {7'd0, m_shift[7]};
    end
    m_phase = ST_IDLE;
    m_left  = '0;
    m_done  = 1'b1;
  endfunction

  function automatic void open_slot();
    if (m_kind == OP_WRITE) begin
      m_phase = ST_W_LOW;
      m_left  = ticks_of(m_shift[0] ? m_cfg[REG_SLOT_SHORT] : m_cfg[REG_SLOT_LONG]);
    end else begin
      m_phase = ST_R_LOW;
      m_left  = ticks_of(m_cfg[REG_READ_LOW]);
    end
  endfunction

  function automatic void close_bit();
    if (m_kind == OP_WRITE) m_shift = m_shift >> 1;
    if (m_bits > 0) m_bits = m_bits - 1'b1;
    if (m_bits == 0) end_command();
    else open_slot();
  endfunction

  // A zero recovery time skips the gap phase altogether.
  function automatic void enter_recovery();
    if (m_cfg[REG_BIT_GAP] == '0) begin
      close_bit();
    end else begin
      m_phase = ST_W_GAP;
      m_left  = ticks_of(m_cfg[REG_BIT_GAP]);
    end
  endfunction

  // Advances the predictor by one tick and returns the outputs of that tick.
  function automatic result_t bus_model_tick(input logic cv, input logic [1:0] op,
                                             input logic [BYTE_W-1:0] wb,
                                             input logic lp, input logic line);
    result_t r;
    m_done = 1'b0;
    if (m_phase == ST_IDLE) begin
      if (cv) begin
        m_power = 1'b0;
        m_kind  = opcode_t'(op);
        m_hold  = lp;
        if (op == OP_RESET) begin
          m_phase = ST_RST_LOW;
          m_left  = ticks_of(m_cfg[REG_RESET_LOW]);
        end else begin
          if (op == OP_WRITE) m_shift = wb;
          m_bits = (op == OP_READ_BIT) ? BITS_W'(1) : BITS_W'(BITS_PER_BYTE);
          open_slot();
        end
      end
    end else if (m_left > 1) begin
      m_left = m_left - 1'b1;
    end else begin
      m_left = '0;
      case (m_phase)
        ST_RST_LOW: begin
          m_phase = ST_RST_WAIT;
          m_left  = ticks_of(m_cfg[REG_PRES_SAMPLE]);
        end
        ST_RST_WAIT: begin
          m_pres  = ~line;
          m_phase = ST_RST_TAIL;
          m_left  = ticks_of(m_cfg[REG_RESET_TAIL]);
        end
        ST_RST_TAIL: end_command();
        ST_W_LOW: begin
          // Parasite power goes on after the last slot, whatever its bit.
          if (m_bits == 1 && m_hold) begin
            m_power = 1'b1;
            enter_recovery();
          end else if (m_shift[0]) begin
            m_phase = ST_W_HIGH;
            m_left  = ticks_of(m_cfg[REG_SLOT_LONG]);
          end else begin
            enter_recovery();
          end
        end
        ST_W_HIGH: enter_recovery();
        ST_W_GAP:  close_bit();
        ST_R_LOW: begin
          m_phase = ST_R_SAMPLE;
          m_left  = TIME_WIDTH'(1);
        end
        ST_R_SAMPLE: begin
          m_shift = {line, m_shift[BYTE_W-1:1]};
          m_phase = ST_R_TAIL;
          m_left  = ticks_of(m_cfg[REG_READ_TAIL]);
        end
        ST_R_TAIL: close_bit();
        default: begin
          m_phase = ST_IDLE;
          m_left  = '0;
        end
      endcase
    end
    r.drive_low   = (m_phase == ST_RST_LOW) || (m_phase == ST_W_LOW) || (m_phase == ST_R_LOW);
    r.strong_high = m_power;
    r.busy_res    = (m_phase != ST_IDLE);
    r.done_res    = m_done;
    r.presence    = m_pres;
    r.read_value  = m_rdval;
    return r;
  endfunction

  // Sends one tick, in bursts with random gaps, and records its expected outputs.
  task automatic send_tick(input logic cv, input logic [1:0] op, input logic [BYTE_W-1:0] wb,
                           input logic lp, input logic line);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    tick_ch.valid         <= 1'b1;
    tick_ch.cmd_valid     <= cv;
    tick_ch.opcode        <= op;
    tick_ch.write_byte    <= wb;
    tick_ch.leave_powered <= lp;
    tick_ch.line_level    <= line;
    do @(posedge clk); while (!tick_ch.ready);
    pending_res_q.push_back(bus_model_tick(cv, op, wb, lp, line));
    if (burst_left > 0) burst_left--;
  endtask

  // Issues one command and keeps ticking until it completes. The line is held
  // at the wanted level on presence and read samples and is random elsewhere;
  // with noise set, further commands are offered while busy.
  task automatic run_command(input logic [1:0] op, input logic [BYTE_W-1:0] wb,
                             input logic lp, input logic [BYTE_W-1:0] rd_bits,
                             input logic pres_line, input bit noise);
    logic              line;
    logic              cv;
    logic [BITS_W-1:0] idx;
    send_tick(1'b1, op, wb, lp, 1'($urandom));
    while (m_phase != ST_IDLE) begin
      idx = BITS_W'(BITS_PER_BYTE) - m_bits;
      if (m_phase == ST_R_SAMPLE) line = rd_bits[idx[2:0]];
      else if (m_phase == ST_RST_WAIT) line = pres_line;
      else line = 1'($urandom);
      cv = noise && ($urandom_range(0, 3) == 0);
      send_tick(cv, 2'($urandom), 8'($urandom), 1'($urandom), line);
    end
    repeat ($urandom_range(0, 2)) send_tick(1'b0, 2'($urandom), 8'($urandom), 1'($urandom),
                                             1'($urandom));
  endtask

  // Writes all timing registers once the unit is idle and every result is in.
  task automatic load_timing(input logic [CFG_COUNT-1:0][CFG_W-1:0] vals);
    tick_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_res_q.size() != 0) @(posedge clk);
    for (int i = 0; i < CFG_COUNT; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= vals[i];
      m_cfg[i] = vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Standard timings straight after reset: a powered write whose last bit is
  // zero, then a single bit read.
  task automatic test_default_timing();
    run_command(OP_WRITE, 8'h21, 1'b1, 8'h00, 1'b1, 1'b1);
    run_command(OP_READ_BIT, 8'h00, 1'b1, 8'h80, 1'b1, 1'b0);
  endtask

  // All registers zero: one-tick phases and no write recovery.
  task automatic test_shortest_timing();
    load_timing('0);
    run_command(OP_RESET, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1);
    run_command(OP_WRITE, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b1);
    run_command(OP_WRITE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    run_command(OP_READ, 8'h00, 1'b0, 8'hFF, 1'b0, 1'b1);
    run_command(OP_READ, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0);
    run_command(OP_READ_BIT, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1);
  endtask

  // All registers one: the lowest real timings, recovery included.
  task automatic test_unit_timing();
    logic [CFG_COUNT-1:0][CFG_W-1:0] vals;
    for (int i = 0; i < CFG_COUNT; i++) vals[i] = CFG_W'(1);
    load_timing(vals);
    run_command(OP_RESET, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0);
    run_command(OP_WRITE, 8'hA5, 1'b1, 8'h00, 1'b0, 1'b1);
    run_command(OP_WRITE, 8'h7F, 1'b1, 8'h00, 1'b0, 1'b1);
    run_command(OP_READ, 8'h00, 1'b0, 8'hC3, 1'b0, 1'b1);
    run_command(OP_READ_BIT, 8'h00, 1'b0, 8'hFF, 1'b0, 1'b0);
    run_command(OP_RESET, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1);
  endtask

  // Random commands under a series of random small timings.
  task automatic test_random_traffic();
    logic [CFG_COUNT-1:0][CFG_W-1:0] vals;
    for (int s = 0; s < 4; s++) begin
      for (int i = 0; i < CFG_COUNT; i++) begin
        vals[i] = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(7, 12))
                                              : CFG_W'($urandom_range(0, 6));
      end
      load_timing(vals);
      for (int c = 0; c < 4; c++) begin
        run_command(2'($urandom), 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                    1'($urandom));
      end
    end
  endtask

  // Result receiver: stalls in stretches of changing character.
  initial begin
    int        mode;
    int        len;
    logic [7:0] mask;
    res_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(8, 64);
      mask = 8'($urandom) | 8'h01;
      repeat (len) begin
        @(posedge clk);
        if (mode == 0) begin
          res_ch.ready <= 1'b1;
        end else if (mode == 1) begin
          res_ch.ready <= ($urandom_range(0, 3) != 0);
        end else begin
          res_ch.ready <= mask[0];
          mask = {mask[0], mask[7:1]};
        end
      end
    end
  end

  // Result checker: each result transfer against the oldest expectation.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.drive_low   = res_ch.drive_low;
      got.strong_high = res_ch.strong_high;
      got.busy_res    = res_ch.busy_res;
      got.done_res    = res_ch.done_res;
      got.presence    = res_ch.presence;
      got.read_value  = res_ch.read_value;
      if (pending_res_q.size() == 0) begin
        bad_count++;
        if (bad_count <= REPORT_LIMIT) $display("unexpected result transfer");
      end else begin
        want = pending_res_q.pop_front();
        if (got !== want) begin
          bad_count++;
          if (bad_count <= REPORT_LIMIT) begin
            $display("mismatch: drive_low %b/%b strong_high %b/%b busy %b/%b done %b/%b",
                     want.drive_low, got.drive_low, want.strong_high, got.strong_high,
                     want.busy_res, got.busy_res, want.done_res, got.done_res);
            $display("          presence %b/%b read_value %h/%h (expected/actual)",
                     want.presence, got.presence, want.read_value, got.read_value);
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("one_wire_bus_master_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence.
  initial begin
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= '0;
    cfg_data              <= '0;
    tick_ch.valid         <= 1'b0;
    tick_ch.cmd_valid     <= 1'b0;
    tick_ch.opcode        <= OP_RESET;
    tick_ch.write_byte    <= '0;
    tick_ch.leave_powered <= 1'b0;
    tick_ch.line_level    <= 1'b1;

    // Predictor comes up as the unit does after reset.
    m_cfg[REG_RESET_LOW]   = 16'd480;
    m_cfg[REG_PRES_SAMPLE] = 16'd65;
    m_cfg[REG_RESET_TAIL]  = 16'd400;
    m_cfg[REG_SLOT_LONG]   = 16'd40;
    m_cfg[REG_SLOT_SHORT]  = 16'd1;
    m_cfg[REG_BIT_GAP]     = 16'd5;
    m_cfg[REG_READ_LOW]    = 16'd2;
    m_cfg[REG_READ_TAIL]   = 16'd40;
    m_phase = ST_IDLE;
    m_left  = '0;
    m_bits  = '0;
    m_shift = '0;
    m_kind  = OP_RESET;
    m_pres  = 1'b0;
    m_hold  = 1'b0;
    m_power = 1'b0;
    m_done  = 1'b0;
    m_rdval = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_default_timing();
    test_shortest_timing();
    test_unit_timing();
    test_random_traffic();

    // Drain the remaining results before the final report.
    tick_ch.valid <= 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (bad_count == 0) begin
      $display("one_wire_bus_master_unit verification clean");
    end else begin
      $display("one_wire_bus_master_unit verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/obw_pkg.sv
src/obw_ifs.sv
src/obw_cfg.sv
src/obw_core.sv
src/one_wire_bus_master_unit.sv
tb/tb_top.sv
